// ===== design/emboss_5x5_rgb_filter_macros.svh =====
// Assertion macros for the emboss filter checker.
// Depends on nothing; every macro samples on the rising edge of clock.
`ifndef EMBOSS_5X5_RGB_FILTER_MACROS_SVH
`define EMBOSS_5X5_RGB_FILTER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define EMB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define EMB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define EMB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/emb_pkg.sv =====
// Shared types, constants and register codes of the 5x5 RGB emboss filter.
// No dependencies.
package emb_pkg;

   localparam int MAX_LINE_WIDTH_DEF = 1024;
   localparam int MAX_ROWS_DEF       = 1024;

   localparam int GAIN_W   = 4;
   localparam int LEVEL_W  = 8;
   localparam int WIDTH_W  = 11;
   localparam int START_W  = 10;
   localparam int POS_W    = 10;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BIAS         = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CLAMP_LOW    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CLAMP_HIGH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_START_COL    = 3'd5;

   localparam logic [GAIN_W-1:0]  GAIN_RST         = 4'd1;
   localparam logic [LEVEL_W-1:0] BIAS_RST         = 8'd128;
   localparam logic [LEVEL_W-1:0] CLAMP_LOW_RST    = 8'd16;
   localparam logic [LEVEL_W-1:0] CLAMP_HIGH_RST   = 8'd240;
   localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RST = 11'd720;
   localparam logic [START_W-1:0] START_COL_RST    = 10'd0;

   // Arithmetic widths: row of four signed 8-bit terms, total of twenty,
   // gain times total plus bias.
   localparam int ROW_SUM_W = 11;
   localparam int TOTAL_W   = 14;
   localparam int SCALED_W  = 19;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } pixel_type;

   // [row][col], row 0 oldest line, col 0 oldest column
   typedef pixel_type [4:0][4:0] window_type;
   // [3] is the line four back, [0] the previous line
   typedef pixel_type [3:0] line_word_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       red_out;
      logic [7:0]       green_out;
      logic [7:0]       blue_out;
      logic [POS_W-1:0] center_row;
      logic [POS_W-1:0] center_col;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain;
      logic [LEVEL_W-1:0] bias;
      logic [LEVEL_W-1:0] clamp_low;
      logic [LEVEL_W-1:0] clamp_high;
      logic [WIDTH_W-1:0] active_width;
      logic [START_W-1:0] start_col;
   } cfg_type;

endpackage

// ===== design/emb_csr.sv =====
// APB-style register file of the emboss filter.
// Depends on emb_pkg.
module emb_csr
   import emb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_strobe;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_GAIN:         cfg_in.gain         = csr_pwdata[GAIN_W-1:0];
            REG_BIAS:         cfg_in.bias         = csr_pwdata[LEVEL_W-1:0];
            REG_CLAMP_LOW:    cfg_in.clamp_low    = csr_pwdata[LEVEL_W-1:0];
            REG_CLAMP_HIGH:   cfg_in.clamp_high   = csr_pwdata[LEVEL_W-1:0];
            REG_ACTIVE_WIDTH: cfg_in.active_width = csr_pwdata[WIDTH_W-1:0];
            REG_START_COL:    cfg_in.start_col    = csr_pwdata[START_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= GAIN_RST;
         cfg_ff.bias         <= BIAS_RST;
         cfg_ff.clamp_low    <= CLAMP_LOW_RST;
         cfg_ff.clamp_high   <= CLAMP_HIGH_RST;
         cfg_ff.active_width <= ACTIVE_WIDTH_RST;
         cfg_ff.start_col    <= START_COL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN:         csr_prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_BIAS:         csr_prdata = CSR_DATA_W'(cfg_ff.bias);
         REG_CLAMP_LOW:    csr_prdata = CSR_DATA_W'(cfg_ff.clamp_low);
         REG_CLAMP_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.clamp_high);
         REG_ACTIVE_WIDTH: csr_prdata = CSR_DATA_W'(cfg_ff.active_width);
         REG_START_COL:    csr_prdata = CSR_DATA_W'(cfg_ff.start_col);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/emb_kernel.sv =====
// Emboss arithmetic: row sums, window total, gain/bias/clamp, result register.
// Depends on emb_pkg.
module emb_kernel
   import emb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [POS_W-1:0] in_row,
   input  logic [POS_W-1:0] in_col,
   input  window_type       window,
   input  cfg_type          cfg,
   output logic             out_valid,
   output rsp_payload_type  out_payload
);

   // stage A: per-row signed sums
   logic signed [ROW_SUM_W-1:0] row_sum_in [3][5];
   logic signed [ROW_SUM_W-1:0] row_sum_ff [3][5];
   logic                        a_valid_ff;
   logic [POS_W-1:0]            a_row_ff;
   logic [POS_W-1:0]            a_col_ff;

   // stage B: window total per channel
   logic signed [TOTAL_W-1:0]   total_in [3];
   logic signed [TOTAL_W-1:0]   total_ff [3];
   logic                        b_valid_ff;
   logic [POS_W-1:0]            b_row_ff;
   logic [POS_W-1:0]            b_col_ff;

   // stage C: scaled and clamped
   logic [LEVEL_W-1:0]          level_in [3];
   logic                        out_valid_ff;
   rsp_payload_type             out_payload_ff;

   function automatic logic [LEVEL_W-1:0] chan(input pixel_type p, input int ch);
      logic [LEVEL_W-1:0] v;
      case (ch)
         0:       v = p.red;
         1:       v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

   // -1 above the anti-diagonal, +1 below, 0 on it
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 5; i++) begin
            logic signed [ROW_SUM_W-1:0] acc;
            logic signed [ROW_SUM_W-1:0] term;
            acc = '0;
            for (int j = 0; j < 5; j++) begin
               term = $signed(ROW_SUM_W'(chan(window[i][j], ch)));
               if (i + j < 4) begin
                  acc = acc - term;
               end else if (i + j > 4) begin
                  acc = acc + term;
               end
            end
            row_sum_in[ch][i] = acc;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic signed [TOTAL_W-1:0] acc;
         acc = '0;
         for (int i = 0; i < 5; i++) begin
            acc = acc + TOTAL_W'(row_sum_ff[ch][i]);
         end
         total_in[ch] = acc;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic signed [SCALED_W-1:0] scaled;
         logic signed [SCALED_W-1:0] lo;
         logic signed [SCALED_W-1:0] hi;
         scaled = SCALED_W'($signed({1'b0, cfg.gain})) * SCALED_W'(total_ff[ch])
                + SCALED_W'($signed({1'b0, cfg.bias}));
         lo = SCALED_W'($signed({1'b0, cfg.clamp_low}));
         hi = SCALED_W'($signed({1'b0, cfg.clamp_high}));
         if (scaled < lo) begin
            level_in[ch] = cfg.clamp_low;
         end else if (scaled > hi) begin
            level_in[ch] = cfg.clamp_high;
         end else begin
            level_in[ch] = scaled[LEVEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         row_sum_ff <= row_sum_in;
         a_row_ff   <= in_row;
         a_col_ff   <= in_col;
         total_ff   <= total_in;
         b_row_ff   <= a_row_ff;
         b_col_ff   <= a_col_ff;
         out_payload_ff.red_out    <= level_in[0];
         out_payload_ff.green_out  <= level_in[1];
         out_payload_ff.blue_out   <= level_in[2];
         out_payload_ff.center_row <= b_row_ff;
         out_payload_ff.center_col <= b_col_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_payload = out_payload_ff;

endmodule

// ===== design/emboss_5x5_rgb_filter.sv =====
// Streaming 5x5 emboss filter on RGB pixels; one pixel enters per clock in raster
// order unless stalled, and at most one filtered pixel leaves per pixel entered.
// Built on emb_pkg, emb_csr (register file) and emb_kernel (mask arithmetic).
//
// Rate: one pixel transfer per clock while req_stall is low. A result passes in
// turn through the memory read, window shift, row sums, total and scale registers
// after the transfer of the pixel that completes its window. req_stall is high
// only while a result sits in the output register and rsp_stall holds it; the
// whole pipeline then freezes in place. The line store is one memory of
// MAX_LINE_WIDTH words, each word holding the four previous lines of one column;
// it is read once and written once per pixel, with a one-deep bypass for
// back-to-back reuse of a column. It needs no clearing pass: a column is always
// written before a complete window reads it. A result is given for a centre at
// least two pixels inside the frame and at or right of start_col; the last two
// rows of a frame give none. Row and column count modulo the effective width
// (active_width capped at MAX_LINE_WIDTH, zero counting as one) and MAX_ROWS;
// frame_start restarts both. The user must write configuration only while the
// pipeline is empty; the block itself does not enforce it.
module emboss_5x5_rgb_filter
   import emb_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
   parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   // filtered output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW   = $clog2(MAX_LINE_WIDTH);       // column / memory address
   localparam int RW   = $clog2(MAX_ROWS);             // row count
   localparam int CW   = $clog2(MAX_LINE_WIDTH + 1);
   localparam int WW   = (CW > WIDTH_W) ? CW : WIDTH_W; // width compare domain
   localparam int CMPW = (AW > START_W) ? AW : START_W; // start column compare

   cfg_type cfg;

   emb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   // pipeline moves unless a result is held at the output
   logic advance;
   logic accept;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ---------------- position counters (transfer cycle) ----------------
   logic [AW-1:0]  col_count_ff, col_count_in;
   logic [RW-1:0]  row_count_ff, row_count_in;
   logic [WW-1:0]  eff_width;
   logic [WW-1:0]  width_cap;
   logic [AW-1:0]  col_start, col_cur;
   logic [RW-1:0]  row_cur;
   logic [WW-1:0]  col_inc;
   logic [RW:0]    row_inc;
   logic           produce;

   always_comb begin
      width_cap = (WW'(cfg.active_width) > WW'(MAX_LINE_WIDTH)) ?
                  WW'(MAX_LINE_WIDTH) : WW'(cfg.active_width);
      eff_width = (width_cap == '0) ? WW'(1) : width_cap;
   end

   always_comb begin
      // frame start forces row and column to zero before the pixel is placed
      col_start = req_payload.frame_start ? '0 : col_count_ff;
      row_cur   = req_payload.frame_start ? '0 : row_count_ff;
      col_cur   = (WW'(col_start) >= eff_width) ? '0 : col_start;

      produce = (row_cur >= RW'(4)) && (col_cur >= AW'(4)) &&
                (CMPW'(col_cur - AW'(2)) >= CMPW'(cfg.start_col));

      col_inc = WW'(col_cur) + WW'(1);
      row_inc = (RW+1)'(row_cur) + (RW+1)'(1);
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_inc >= eff_width) begin
            col_count_in = '0;
            row_count_in = (row_inc >= (RW+1)'(MAX_ROWS)) ? '0 : row_inc[RW-1:0];
         end else begin
            col_count_in = col_inc[AW-1:0];
            row_count_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ---------------- stage 1: line store read returns ----------------
   logic             s1_valid_ff;
   pixel_type        s1_pix_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             s1_produce_ff;
   logic [POS_W-1:0] s1_row_ff;
   logic [POS_W-1:0] s1_col_ff;

   line_word_type    line_mem [MAX_LINE_WIDTH];
   line_word_type    rd_word_ff;
   line_word_type    fwd_word_ff;
   logic             fwd_sel_ff;
   line_word_type    old_word;
   line_word_type    new_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= '{red: req_payload.red_in, green: req_payload.green_in,
                            blue: req_payload.blue_in};
         s1_addr_ff    <= col_cur;
         s1_produce_ff <= produce;
         s1_row_ff     <= POS_W'(row_cur - RW'(2));
         s1_col_ff     <= POS_W'(col_cur - AW'(2));
      end
   end

   // read at the transfer; a write to the same column in that cycle is bypassed
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_word_ff  <= line_mem[col_cur];
         fwd_word_ff <= new_word;
         fwd_sel_ff  <= s1_valid_ff && (s1_addr_ff == col_cur);
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         line_mem[s1_addr_ff] <= new_word;
      end
   end

   assign old_word = fwd_sel_ff ? fwd_word_ff : rd_word_ff;
   assign new_word = {old_word[2], old_word[1], old_word[0], s1_pix_ff};

   // ---------------- window shift ----------------
   window_type window_ff;

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
               window_ff[i][j] <= window_ff[i][j+1];
            end
         end
         window_ff[0][4] <= old_word[3];
         window_ff[1][4] <= old_word[2];
         window_ff[2][4] <= old_word[1];
         window_ff[3][4] <= old_word[0];
         window_ff[4][4] <= s1_pix_ff;
      end
   end

   // ---------------- stage 2: window holds this item's pixels ----------------
   logic             s2_produce_ff;
   logic [POS_W-1:0] s2_row_ff;
   logic [POS_W-1:0] s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_produce_ff <= 1'b0;
      end else if (advance) begin
         s2_produce_ff <= s1_valid_ff && s1_produce_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
      end
   end

   emb_kernel u_kernel (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s2_produce_ff),
      .in_row     (s2_row_ff),
      .in_col     (s2_col_ff),
      .window     (window_ff),
      .cfg        (cfg),
      .out_valid  (rsp_valid),
      .out_payload(rsp_payload)
   );

endmodule

// ===== design/emb_checker.sv =====
// Port-level checker of the emboss filter, bound to the top level.
// Depends on emb_pkg and emboss_5x5_rgb_filter_macros.svh.
`include "emboss_5x5_rgb_filter_macros.svh"

module emb_checker
   import emb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // input side is held back only by a result waiting at the output
   `EMB_ASSERT_NOW(stall_only_when_blocked, req_stall, rsp_valid && rsp_stall, "bad req_stall")

   // a held result stays put
   `EMB_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "held")

   // output register empties on reset
   `EMB_ASSERT_NEXT_ALWAYS(no_result_after_reset, reset, !rsp_valid, "result present after reset")

   // pipeline keeps flowing: an empty output never stalls the input
   `EMB_ASSERT_NOW(flow_when_free, !rsp_valid, !req_stall, "input stalled with empty output")

endmodule

bind emboss_5x5_rgb_filter emb_checker u_emb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

// ===== tb/sv/emboss_5x5_rgb_filter_tb.sv =====
// Self-checking testbench for the 5x5 RGB emboss filter: streams pixel frames,
// predicts every filtered pixel and compares each field of the result channel.
// Depends on emb_pkg and emboss_5x5_rgb_filter.
`timescale 1ns / 100ps

module emboss_5x5_rgb_filter_tb;
   import emb_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   // margin after the last transfer for the pipeline to run dry
   localparam int DRAIN_CYCLES  = 12;
   // cycles without any transfer or register access before giving up
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 1150;

   typedef enum {CH_RED, CH_GREEN, CH_BLUE} channel_type;
   typedef enum {FILL_RANDOM, FILL_EXTREME} fill_type;

   // ---------------------------------------------------------------
   // DUT connections, every driven input known from time zero
   // ---------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   emboss_5x5_rgb_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Filter predictor state: four previous lines per column, the 5x5
   // window (row 0 = oldest line, col 0 = oldest column), the raster
   // position of the next pixel and a copy of the register settings.
   // ---------------------------------------------------------------
   pixel_type       line_mem [4][MAX_LINE_WIDTH_DEF];
   pixel_type       taps     [5][5];
   int unsigned     row_cnt = 0;
   int unsigned     col_cnt = 0;
   cfg_type         model_cfg;

   req_payload_type pixel_q[$];       // pixels waiting for the driver
   rsp_payload_type filtered_due[$];  // predicted filtered pixels, oldest first
   rsp_payload_type oldest;

   int unsigned pushed_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count  = 0;
   int unsigned error_count    = 0;
   int unsigned setting_count  = 0;
   int unsigned idle_cycles    = 0;
   bit          steady         = 1'b0;  // suppresses random idling on both sides

   // Mask sum of one channel: -1 above the anti-diagonal, +1 below it,
   // then gain, bias and the clamp. With crossed clamps the low test wins
   // first, anything else lands on clamp_high.
   function automatic logic [7:0] emboss_level(channel_type ch);
      int sum;
      int lvl;
      int p;
      sum = 0;
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 5; j++) begin
            case (ch)
               CH_RED:   p = int'(taps[i][j].red);
               CH_GREEN: p = int'(taps[i][j].green);
               default:  p = int'(taps[i][j].blue);
            endcase
            if (i + j < 4) sum -= p;
            else if (i + j > 4) sum += p;
         end
      end
      lvl = int'(model_cfg.gain) * sum + int'(model_cfg.bias);
      if (lvl < int'(model_cfg.clamp_low)) lvl = int'(model_cfg.clamp_low);
      else if (lvl > int'(model_cfg.clamp_high)) lvl = int'(model_cfg.clamp_high);
      return 8'(lvl);
   endfunction

   // Advance the predictor by one accepted pixel; queue a filtered pixel
   // when the window is complete and its centre is inside the margins.
   function automatic void filter_pixel(req_payload_type px);
      pixel_type       pix;
      pixel_type       column [5];
      int unsigned     w;
      int unsigned     row;
      int unsigned     col;
      rsp_payload_type res;
      pix = {px.red_in, px.green_in, px.blue_in};
      w = int'(model_cfg.active_width);
      if (w > MAX_LINE_WIDTH_DEF) w = MAX_LINE_WIDTH_DEF;
      if (w == 0) w = 1;
      if (px.frame_start) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      row = row_cnt;
      col = col_cnt;

      column[0] = line_mem[3][col];
      column[1] = line_mem[2][col];
      column[2] = line_mem[1][col];
      column[3] = line_mem[0][col];
      column[4] = pix;
      line_mem[3][col] = line_mem[2][col];
      line_mem[2][col] = line_mem[1][col];
      line_mem[1][col] = line_mem[0][col];
      line_mem[0][col] = pix;

      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 4; j++) taps[i][j] = taps[i][j+1];
         taps[i][4] = column[i];
      end

      if (row >= 4 && col >= 4 && col - 2 >= int'(model_cfg.start_col)) begin
         res.red_out    = emboss_level(CH_RED);
         res.green_out  = emboss_level(CH_GREEN);
         res.blue_out   = emboss_level(CH_BLUE);
         res.center_row = POS_W'(row - 2);
         res.center_col = POS_W'(col - 2);
         filtered_due.push_back(res);
      end

      col_cnt = col + 1;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt = row + 1;
         if (row_cnt >= MAX_ROWS_DEF) row_cnt = 0;
      end
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // Pixel driver: a new pixel is offered only once the previous one
   // has transferred, and it holds steady while stalled.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_pixel(req_payload);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() > 0 && (steady || $urandom_range(99) >= 16)) begin
               req_payload <= pixel_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: each transfer is compared with the oldest prediction.
   // Back-pressure is random except during the steady stretch.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected result, expected none, got %p",
                        $time, rsp_payload);
            end else begin
               oldest = filtered_due.pop_front();
               check_field("red_out", int'(oldest.red_out), int'(rsp_payload.red_out));
               check_field("green_out", int'(oldest.green_out),
                           int'(rsp_payload.green_out));
               check_field("blue_out", int'(oldest.blue_out), int'(rsp_payload.blue_out));
               check_field("center_row", int'(oldest.center_row),
                           int'(rsp_payload.center_row));
               check_field("center_col", int'(oldest.center_col),
                           int'(rsp_payload.center_col));
               checked_count++;
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 16);
      end
   end

   // Watchdog: no transfer on either channel and no register access
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, filtered_due.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Register access: setup + access write, then a read-back.
   // ---------------------------------------------------------------
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] mask;
      case (idx)
         REG_GAIN: begin
            model_cfg.gain = value[GAIN_W-1:0];
            mask = (1 << GAIN_W) - 1;
         end
         REG_BIAS: begin
            model_cfg.bias = value[LEVEL_W-1:0];
            mask = (1 << LEVEL_W) - 1;
         end
         REG_CLAMP_LOW: begin
            model_cfg.clamp_low = value[LEVEL_W-1:0];
            mask = (1 << LEVEL_W) - 1;
         end
         REG_CLAMP_HIGH: begin
            model_cfg.clamp_high = value[LEVEL_W-1:0];
            mask = (1 << LEVEL_W) - 1;
         end
         REG_ACTIVE_WIDTH: begin
            model_cfg.active_width = value[WIDTH_W-1:0];
            mask = (1 << WIDTH_W) - 1;
         end
         REG_START_COL: begin
            model_cfg.start_col = value[START_W-1:0];
            mask = (1 << START_W) - 1;
         end
         default: mask = '0;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);               // write lands here
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);               // read data sampled in the access cycle
      check_field("register read-back", value & mask, csr_prdata & mask);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_settings(input int unsigned gain, input int unsigned bias,
                                input int unsigned lo, input int unsigned hi,
                                input int unsigned width, input int unsigned start);
      write_reg(REG_GAIN, gain);
      write_reg(REG_BIAS, bias);
      write_reg(REG_CLAMP_LOW, lo);
      write_reg(REG_CLAMP_HIGH, hi);
      write_reg(REG_ACTIVE_WIDTH, width);
      write_reg(REG_START_COL, start);
      setting_count++;
   endtask

   // Wait until every queued pixel has transferred and every prediction has
   // been matched, then let the pipeline run dry (trailing pixels that give
   // no result may still be inside).
   task automatic settle();
      while (accepted_count < pushed_count || filtered_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One frame of n pixels; frame_start on the first, plus occasional
   // stray frame_start marks as noise.
   task automatic push_frame(input int unsigned n, input fill_type fill,
                             input int unsigned noise_pct);
      req_payload_type px;
      for (int unsigned k = 0; k < n; k++) begin
         px.frame_start = (k == 0) || ($urandom_range(99) < noise_pct);
         if (fill == FILL_EXTREME) begin
            px.red_in   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue_in  = $urandom_range(1) ? 8'hFF : 8'h00;
         end else begin
            px.red_in   = 8'($urandom_range(255));
            px.green_in = 8'($urandom_range(255));
            px.blue_in  = 8'($urandom_range(255));
         end
         pixel_q.push_back(px);
         pushed_count++;
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------
   initial begin
      req_payload_type px;
      int unsigned     random_pixels;
      int unsigned     phase;
      int unsigned     pick;
      int unsigned     width;
      int unsigned     start;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     tmp;
      int unsigned     n;

      random_pixels = 0;
      phase = 0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (taps[i, j]) taps[i][j] = '0;
      model_cfg = '{gain: GAIN_RST, bias: BIAS_RST, clamp_low: CLAMP_LOW_RST,
                    clamp_high: CLAMP_HIGH_RST, active_width: ACTIVE_WIDTH_RST,
                    start_col: START_COL_RST};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Directed 5x5 frame: red bright below the anti-diagonal (saturates
      // high), green bright above it (saturates low), flat blue (bias only).
      load_settings(1, 128, 16, 240, 5, 0);
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            px.frame_start = (r == 0 && c == 0);
            px.red_in      = (r + c > 4) ? 8'hFF : 8'h00;
            px.green_in    = (r + c < 4) ? 8'hFF : 8'h00;
            px.blue_in     = 8'd77;
            pixel_q.push_back(px);
            pushed_count++;
         end
      end
      settle();

      // Largest gain, zero bias, full clamp range, saturated channels
      load_settings(15, 0, 0, 255, 5, 0);
      push_frame(35, FILL_EXTREME, 0);
      settle();

      // Zero gain: every result is the bias, clamped to a single level
      load_settings(0, 255, 255, 255, 7, 2);
      push_frame(42, FILL_RANDOM, 0);
      settle();

      // Crossed clamps
      load_settings(2, 100, 200, 50, 6, 3);
      push_frame(42, FILL_RANDOM, 0);
      settle();

      // start_col past the line: no result at all
      load_settings(1, 128, 16, 240, 9, 1023);
      push_frame(54, FILL_RANDOM, 0);
      settle();

      // Widths too narrow for a window; zero behaves as one
      load_settings(3, 7, 0, 255, 0, 0);
      push_frame(12, FILL_RANDOM, 0);
      settle();
      load_settings(3, 7, 0, 255, 3, 0);
      push_frame(20, FILL_RANDOM, 0);
      settle();
      load_settings(3, 7, 0, 255, 4, 0);
      push_frame(24, FILL_RANDOM, 0);
      settle();

      // Random settings and frames, mostly narrow lines; a run of phases
      // goes without any idling on either side.
      while (random_pixels < RANDOM_PIXELS) begin
         phase++;
         steady = (phase >= 3 && phase < 6);

         pick = $urandom_range(99);
         if (pick < 8) width = $urandom_range(4);
         else if (pick < 75) width = $urandom_range(12, 5);
         else width = $urandom_range(40, 13);

         pick = $urandom_range(99);
         if (pick < 55) start = $urandom_range(2);
         else if (pick < 90) start = $urandom_range(width);
         else start = $urandom_range(1023);

         lo = $urandom_range(255);
         hi = $urandom_range(255);
         pick = $urandom_range(99);
         if (pick < 65) begin
            if (lo > hi) begin
               tmp = lo;
               lo  = hi;
               hi  = tmp;
            end
         end else if (pick >= 80) begin
            lo = $urandom_range(1) * 255;
            hi = $urandom_range(1) * 255;
         end

         settle();
         load_settings($urandom_range(15), $urandom_range(255), lo, hi, width, start);
         if (width < 5) n = $urandom_range(30, 5);
         else n = width * $urandom_range(8, 5) + $urandom_range(width - 1);
         push_frame(n, ($urandom_range(3) == 0) ? FILL_EXTREME : FILL_RANDOM, 2);
         random_pixels += n;
      end
      steady = 1'b0;
      settle();

      $display("%0d pixels streamed under %0d register settings", accepted_count,
               setting_count);
      $display("%0d filtered pixels compared, %0d mismatches", checked_count,
               error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/emb_pkg.sv
design/emb_csr.sv
design/emb_kernel.sv
design/emboss_5x5_rgb_filter.sv
design/emb_checker.sv
tb/sv/emboss_5x5_rgb_filter_tb.sv
